// ----- hw/rtl/pcr_pkg.sv -----
// ----------------------------------------------------------------------------
// pcr_pkg: shared types and constants of the pendulum cascade regulator
// Word layouts, register indexes, reset values and Q.16 loop coefficients.
// ----------------------------------------------------------------------------
package pcr_pkg;

   localparam int SAMPLE_W        = 16;  // Q3.12 sample and drive words
   localparam int STATE_W_DEFAULT = 32;  // Q15.16 loop state
   localparam int CFG_W           = 15;
   localparam int CSR_INDEX_W     = 2;
   localparam int CONST_W         = 32;  // unsigned Q.16 coefficients
   localparam int FRAC_W          = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADZONE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIP_ANGLE  = 2'd2;

   localparam logic [CFG_W-1:0] DEADZONE_RESET    = 15'd6554;
   localparam logic [CFG_W-1:0] DRIVE_LIMIT_RESET = 15'd20480;
   localparam logic [CFG_W-1:0] TRIP_ANGLE_RESET  = 15'd6144;

   // sensor zero offsets, Q.16 volts
   localparam logic [CONST_W-1:0] K_PIND_ZERO = 32'd42818;
   localparam logic [CONST_W-1:0] K_ARM_ZERO  = 32'd96888;

   // gains, unsigned Q.16
   localparam logic [CONST_W-1:0] K_INV_TACHO = 32'd2184533;
   localparam logic [CONST_W-1:0] K_RAD_PIND  = 32'd47657;
   localparam logic [CONST_W-1:0] K_RAD_ARM   = 32'd51472;
   localparam logic [CONST_W-1:0] K_TILT      = 32'd15401;
   localparam logic [CONST_W-1:0] K_POLE      = 32'd49159;
   localparam logic [CONST_W-1:0] K_ZERO_NEW  = 32'd1296957;
   localparam logic [CONST_W-1:0] K_ZERO_OLD  = 32'd1243218;
   localparam logic [CONST_W-1:0] K_ARM_GAIN  = 32'd52428800;
   localparam logic [CONST_W-1:0] K_SPD_NEW   = 32'd393216;
   localparam logic [CONST_W-1:0] K_SPD_OLD   = 32'd229363;
   localparam logic [CONST_W-1:0] K_SPD_FB    = 32'd10918;
   localparam logic [CONST_W-1:0] K_SPD_DRV   = 32'd54618;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] tacho_sample;
      logic signed [SAMPLE_W-1:0] arm_sample;
      logic signed [SAMPLE_W-1:0] pend_sample;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] motor_drive;
      logic                       stopped;
   } rsp_word_type;

   typedef struct packed {
      logic [CFG_W-1:0] deadzone_offset;
      logic [CFG_W-1:0] drive_limit;
      logic [CFG_W-1:0] trip_angle;
   } cfg_type;

   typedef struct packed {
      logic start;  // take the input word now
      logic ack;    // finished word moved to the output register
   } seq_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_status_type;

endpackage

// ----- hw/rtl/pcr_mul_unit.sv -----
// ----------------------------------------------------------------------------
// pcr_mul_unit: shared Q.16 coefficient multiplier
// Multiplies a state word by an unsigned Q.16 constant in two passes (integer
// half, then fraction half), rounds half up and saturates.
// ----------------------------------------------------------------------------
module pcr_mul_unit #(
   parameter int STATE_WIDTH = pcr_pkg::STATE_W_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic signed [STATE_WIDTH-1:0]       mul_x,
   input  logic        [pcr_pkg::CONST_W-1:0]  mul_c,
   output logic                                done,
   output logic signed [STATE_WIDTH-1:0]       mul_y
);
   import pcr_pkg::*;

   localparam int PW = STATE_WIDTH + FRAC_W + 1;
   localparam int RW = PW + 1;
   localparam logic signed [PW-1:0] HALF = PW'(2 ** (FRAC_W - 1));
   localparam logic [STATE_WIDTH-1:0] MAXV = {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam logic [STATE_WIDTH-1:0] MINV = {1'b1, {(STATE_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {PH_HIGH, PH_LOW, PH_SUM} phase_type;

   phase_type               phase_ff, phase_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [PW-1:0]    hi_ff, hi_in;
   logic signed [FRAC_W:0]  chunk;
   logic signed [PW-1:0]    prod_mul;
   logic signed [PW-1:0]    rnd;
   logic signed [RW-1:0]    total;
   logic [RW-STATE_WIDTH:0] top_bits;

   assign chunk = (phase_ff == PH_HIGH) ? $signed({1'b0, mul_c[CONST_W-1:FRAC_W]})
                                        : $signed({1'b0, mul_c[FRAC_W-1:0]});
   assign prod_mul = mul_x * chunk;

   always_comb begin
      phase_in = phase_ff;
      prod_in  = prod_ff;
      hi_in    = hi_ff;
      unique case (phase_ff)
         PH_HIGH: begin
            if (go) begin
               prod_in  = prod_mul;
               phase_in = PH_LOW;
            end
         end
         PH_LOW: begin
            hi_in    = prod_ff;
            prod_in  = prod_mul;
            phase_in = PH_SUM;
         end
         PH_SUM: begin
            phase_in = PH_HIGH;
         end
         default: phase_in = PH_HIGH;
      endcase
   end

   // floor((x*c + 2^15) / 2^16) = x*int(c) + floor((x*frac(c) + 2^15) / 2^16)
   always_comb begin
      rnd      = (prod_ff + HALF) >>> FRAC_W;
      total    = RW'(hi_ff) + RW'(rnd);
      top_bits = total[RW-1:STATE_WIDTH-1];
      if ((&top_bits) || !(|top_bits)) begin
         mul_y = total[STATE_WIDTH-1:0];
      end else begin
         mul_y = total[RW-1] ? MINV : MAXV;
      end
   end

   assign done = (phase_ff == PH_SUM);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HIGH;
      end else begin
         phase_ff <= phase_in;
      end
      prod_ff <= prod_in;
      hi_ff   <= hi_in;
   end

endmodule

// ----- hw/rtl/pcr_sequencer.sv -----
// ----------------------------------------------------------------------------
// pcr_sequencer: control-law sequencer and saturating ALU
// Steps through the pendulum, arm and speed loops one operation a cycle, save
// while a multiply waits on the shared unit; holds loop state and stop latch.
// ----------------------------------------------------------------------------
module pcr_sequencer #(
   parameter int STATE_WIDTH = pcr_pkg::STATE_W_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pcr_pkg::seq_ctl_type                ctl,
   output pcr_pkg::seq_status_type             status,
   input  pcr_pkg::req_word_type               req,
   input  pcr_pkg::cfg_type                    cfg,
   output pcr_pkg::rsp_word_type               rsp,
   output logic                                mul_go,
   output logic signed [STATE_WIDTH-1:0]       mul_x,
   output logic        [pcr_pkg::CONST_W-1:0]  mul_c,
   input  logic                                mul_done,
   input  logic signed [STATE_WIDTH-1:0]       mul_y
);
   import pcr_pkg::*;

   localparam int SW = STATE_WIDTH;
   localparam logic [SW-1:0] MAXV = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] MINV = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0] ARM_ZERO_S  = SW'(K_ARM_ZERO);
   localparam logic signed [SW-1:0] PIND_ZERO_S = SW'(K_PIND_ZERO);
   localparam logic signed [SW:0]   DRV_ROUND   = (SW+1)'(8);

   typedef enum logic [4:0] {
      S_IDLE, S_ARM_OFS, S_ARM_RAD, S_TRIP, S_TACHO, S_PEND_OFS, S_PEND_RAD,
      S_SUM, S_TILT, S_VF, S_NEG, S_POLE, S_ZNEW, S_PSUB, S_ZOLD, S_PEND_OUT,
      S_ARM_ERR, S_ARM_GAIN, S_SPD_ERR, S_SNEW, S_SOLD, S_SSUB, S_SFB, S_SADD,
      S_SDRV, S_SPD_OUT, S_DEADZONE, S_CLAMP, S_END
   } state_type;

   state_type            state_ff, state_in;
   logic                 stop_ff, stop_in;
   logic signed [SW-1:0] t_ff, t_in;       // tacho, then speed
   logic signed [SW-1:0] a_ff, a_in;       // arm sample, then errors
   logic signed [SW-1:0] p_ff, p_in;       // pendulum sample, then products
   logic signed [SW-1:0] ta_ff, ta_in;     // arm angle
   logic signed [SW-1:0] acc_ff, acc_in;
   logic signed [SW-1:0] pend_out_ff, pend_out_in;
   logic signed [SW-1:0] pend_err_ff, pend_err_in;
   logic signed [SW-1:0] speed_err_ff, speed_err_in;
   logic signed [SW-1:0] speed_out_ff, speed_out_in;
   logic signed [SW-1:0] drive_ff, drive_in;

   logic signed [SW-1:0] alu_a, alu_b, alu_y;
   logic                 alu_sub;
   logic        [SW:0]   alu_sum;

   logic signed [SW-1:0] dz_s, lim_s, clamp_y;
   logic signed [SW:0]   ta_x, trip_x;
   logic                 trip_hit;
   logic signed [SW:0]   drv_rnd, drv_sh;
   logic [SW-SAMPLE_W+1:0] drv_top;
   logic signed [SAMPLE_W-1:0] drv_q;

   function automatic logic signed [SW-1:0] widen(input logic signed [SAMPLE_W-1:0] s);
      widen = {{(SW-SAMPLE_W-4){s[SAMPLE_W-1]}}, s, 4'b0000};
   endfunction

   // saturating add/subtract, shared by every add step
   always_comb begin
      if (alu_sub) begin
         alu_sum = {alu_a[SW-1], alu_a} - {alu_b[SW-1], alu_b};
      end else begin
         alu_sum = {alu_a[SW-1], alu_a} + {alu_b[SW-1], alu_b};
      end
      if (alu_sum[SW] != alu_sum[SW-1]) begin
         alu_y = alu_sum[SW] ? MINV : MAXV;
      end else begin
         alu_y = alu_sum[SW-1:0];
      end
   end

   always_comb begin
      dz_s   = SW'({cfg.deadzone_offset, 4'b0000});
      lim_s  = SW'({cfg.drive_limit, 4'b0000});
      ta_x   = {ta_ff[SW-1], ta_ff};
      trip_x = (SW+1)'({cfg.trip_angle, 4'b0000});
      trip_hit = (ta_x > trip_x) || (ta_x < -trip_x);
      if (acc_ff > lim_s) begin
         clamp_y = lim_s;
      end else if (acc_ff < -lim_s) begin
         clamp_y = -lim_s;
      end else begin
         clamp_y = acc_ff;
      end
   end

   // drive word: floor((u + 8) / 16), saturated to the sample width
   always_comb begin
      drv_rnd = {drive_ff[SW-1], drive_ff} + DRV_ROUND;
      drv_sh  = drv_rnd >>> 4;
      drv_top = drv_sh[SW:SAMPLE_W-1];
      if ((&drv_top) || !(|drv_top)) begin
         drv_q = drv_sh[SAMPLE_W-1:0];
      end else begin
         drv_q = drv_sh[SW] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      stop_in      = stop_ff;
      t_in         = t_ff;
      a_in         = a_ff;
      p_in         = p_ff;
      ta_in        = ta_ff;
      acc_in       = acc_ff;
      pend_out_in  = pend_out_ff;
      pend_err_in  = pend_err_ff;
      speed_err_in = speed_err_ff;
      speed_out_in = speed_out_ff;
      drive_in     = drive_ff;
      alu_a        = acc_ff;
      alu_b        = p_ff;
      alu_sub      = 1'b0;
      mul_go       = 1'b0;
      mul_x        = acc_ff;
      mul_c        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               if (stop_ff) begin
                  state_in = S_END;
               end else begin
                  t_in     = widen(req.tacho_sample);
                  a_in     = widen(req.arm_sample);
                  p_in     = widen(req.pend_sample);
                  state_in = S_ARM_OFS;
               end
            end
         end
         S_ARM_OFS: begin
            alu_a    = a_ff;
            alu_b    = ARM_ZERO_S;
            alu_sub  = 1'b1;
            acc_in   = alu_y;
            state_in = S_ARM_RAD;
         end
         S_ARM_RAD: begin
            mul_go = 1'b1;
            mul_x  = acc_ff;
            mul_c  = K_RAD_ARM;
            if (mul_done) begin
               ta_in    = mul_y;
               state_in = S_TRIP;
            end
         end
         S_TRIP: begin
            if (trip_hit) begin
               stop_in  = 1'b1;
               state_in = S_END;
            end else begin
               state_in = S_TACHO;
            end
         end
         S_TACHO: begin
            mul_go = 1'b1;
            mul_x  = t_ff;
            mul_c  = K_INV_TACHO;
            if (mul_done) begin
               t_in     = mul_y;
               state_in = S_PEND_OFS;
            end
         end
         S_PEND_OFS: begin
            alu_a    = p_ff;
            alu_b    = PIND_ZERO_S;
            alu_sub  = 1'b1;
            acc_in   = alu_y;
            state_in = S_PEND_RAD;
         end
         S_PEND_RAD: begin
            mul_go = 1'b1;
            mul_x  = acc_ff;
            mul_c  = K_RAD_PIND;
            if (mul_done) begin
               p_in     = mul_y;
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            alu_a    = p_ff;
            alu_b    = ta_ff;
            acc_in   = alu_y;
            state_in = S_TILT;
         end
         S_TILT: begin
            mul_go = 1'b1;
            mul_x  = ta_ff;
            mul_c  = K_TILT;
            if (mul_done) begin
               p_in     = mul_y;
               state_in = S_VF;
            end
         end
         S_VF: begin
            alu_a    = acc_ff;
            alu_b    = p_ff;
            acc_in   = alu_y;
            state_in = S_NEG;
         end
         S_NEG: begin
            alu_a    = '0;
            alu_b    = acc_ff;
            alu_sub  = 1'b1;
            a_in     = alu_y;          // pendulum error
            state_in = S_POLE;
         end
         S_POLE: begin
            mul_go = 1'b1;
            mul_x  = pend_out_ff;
            mul_c  = K_POLE;
            if (mul_done) begin
               p_in     = mul_y;
               state_in = S_ZNEW;
            end
         end
         S_ZNEW: begin
            mul_go = 1'b1;
            mul_x  = a_ff;
            mul_c  = K_ZERO_NEW;
            if (mul_done) begin
               acc_in   = mul_y;
               state_in = S_PSUB;
            end
         end
         S_PSUB: begin
            alu_a    = p_ff;
            alu_b    = acc_ff;
            alu_sub  = 1'b1;
            acc_in   = alu_y;
            state_in = S_ZOLD;
         end
         S_ZOLD: begin
            mul_go = 1'b1;
            mul_x  = pend_err_ff;
            mul_c  = K_ZERO_OLD;
            if (mul_done) begin
               p_in     = mul_y;
               state_in = S_PEND_OUT;
            end
         end
         S_PEND_OUT: begin
            alu_a       = acc_ff;
            alu_b       = p_ff;
            acc_in      = alu_y;
            pend_out_in = alu_y;
            pend_err_in = a_ff;
            state_in    = S_ARM_ERR;
         end
         S_ARM_ERR: begin
            alu_a    = acc_ff;
            alu_b    = ta_ff;
            alu_sub  = 1'b1;
            acc_in   = alu_y;
            state_in = S_ARM_GAIN;
         end
         S_ARM_GAIN: begin
            mul_go = 1'b1;
            mul_x  = acc_ff;
            mul_c  = K_ARM_GAIN;
            if (mul_done) begin
               acc_in   = mul_y;
               state_in = S_SPD_ERR;
            end
         end
         S_SPD_ERR: begin
            alu_a    = acc_ff;
            alu_b    = t_ff;
            a_in     = alu_y;          // speed error
            state_in = S_SNEW;
         end
         S_SNEW: begin
            mul_go = 1'b1;
            mul_x  = a_ff;
            mul_c  = K_SPD_NEW;
            if (mul_done) begin
               acc_in   = mul_y;
               state_in = S_SOLD;
            end
         end
         S_SOLD: begin
            mul_go = 1'b1;
            mul_x  = speed_err_ff;
            mul_c  = K_SPD_OLD;
            if (mul_done) begin
               p_in     = mul_y;
               state_in = S_SSUB;
            end
         end
         S_SSUB: begin
            alu_a    = acc_ff;
            alu_b    = p_ff;
            alu_sub  = 1'b1;
            acc_in   = alu_y;
            state_in = S_SFB;
         end
         S_SFB: begin
            mul_go = 1'b1;
            mul_x  = speed_out_ff;
            mul_c  = K_SPD_FB;
            if (mul_done) begin
               p_in     = mul_y;
               state_in = S_SADD;
            end
         end
         S_SADD: begin
            alu_a    = acc_ff;
            alu_b    = p_ff;
            acc_in   = alu_y;
            state_in = S_SDRV;
         end
         S_SDRV: begin
            mul_go = 1'b1;
            mul_x  = drive_ff;
            mul_c  = K_SPD_DRV;
            if (mul_done) begin
               p_in     = mul_y;
               state_in = S_SPD_OUT;
            end
         end
         S_SPD_OUT: begin
            alu_a        = acc_ff;
            alu_b        = p_ff;
            acc_in       = alu_y;
            speed_out_in = alu_y;
            speed_err_in = a_ff;
            state_in     = S_DEADZONE;
         end
         S_DEADZONE: begin
            // zero drive gets no offset; sign picks add or subtract
            alu_a    = acc_ff;
            alu_b    = (acc_ff == '0) ? '0 : dz_s;
            alu_sub  = acc_ff[SW-1];
            acc_in   = alu_y;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            drive_in = clamp_y;
            state_in = S_END;
         end
         S_END: begin
            if (ctl.ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign status.idle      = (state_ff == S_IDLE);
   assign status.done      = (state_ff == S_END);
   assign rsp.stopped      = stop_ff;
   assign rsp.motor_drive  = stop_ff ? '0 : drv_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stop_ff      <= 1'b0;
         pend_out_ff  <= '0;
         pend_err_ff  <= '0;
         speed_err_ff <= '0;
         speed_out_ff <= '0;
         drive_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         stop_ff      <= stop_in;
         pend_out_ff  <= pend_out_in;
         pend_err_ff  <= pend_err_in;
         speed_err_ff <= speed_err_in;
         speed_out_ff <= speed_out_in;
         drive_ff     <= drive_in;
      end
      t_ff   <= t_in;
      a_ff   <= a_in;
      p_ff   <= p_in;
      ta_ff  <= ta_in;
      acc_ff <= acc_in;
   end

endmodule

// ----- hw/rtl/pendulum_cascade_regulator.sv -----
// ----------------------------------------------------------------------------
// pendulum_cascade_regulator: cascade lead-lag / PI motor drive controller
// Top level: control registers, input handshake, output register and the
// sequencer with its shared multiplier.
// ----------------------------------------------------------------------------
// One sample word (tacho, arm and pendulum voltages) yields one drive word.
// From acceptance to the next ready a word takes twelve Q.16 multiplies on
// the single shared multiplier, fifteen add, compare and clamp steps (adds
// on the saturating ALU) and a hand-off into the output register. While a
// word is in work req_ready is low; the output register lets the next word
// enter while a result waits to be taken. A word that trips the arm-angle
// limit ends after the trip check; once the stop has latched every word goes
// straight to the hand-off with zero drive and stopped set, until reset.
// The user writes control registers only while the block is idle (unchecked).
module pendulum_cascade_regulator #(
   parameter int STATE_WIDTH = pcr_pkg::STATE_W_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pcr_pkg::req_word_type                 req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pcr_pkg::rsp_word_type                 rsp_word,
   input  logic                                  csr_we,
   input  logic [pcr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pcr_pkg::CFG_W-1:0]             csr_wdata
);
   import pcr_pkg::*;

   cfg_type                       cfg_ff, cfg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_word_type                  rsp_word_ff, rsp_word_in;
   seq_ctl_type                   ctl;
   seq_status_type                status;
   rsp_word_type                  seq_rsp;
   logic                          mul_go, mul_done;
   logic signed [STATE_WIDTH-1:0] mul_x, mul_y;
   logic [CONST_W-1:0]            mul_c;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEADZONE:    cfg_in.deadzone_offset = csr_wdata;
            CSR_DRIVE_LIMIT: cfg_in.drive_limit     = csr_wdata;
            CSR_TRIP_ANGLE:  cfg_in.trip_angle      = csr_wdata;
            default:         cfg_in = cfg_ff;   // unmapped index
         endcase
      end
   end

   // output word register frees the sequencer once the result is moved here
   always_comb begin
      ctl.start    = req_valid && status.idle;
      ctl.ack      = status.done && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (ctl.ack) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = seq_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_ready = status.idle && !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadzone_offset <= DEADZONE_RESET;
         cfg_ff.drive_limit     <= DRIVE_LIMIT_RESET;
         cfg_ff.trip_angle      <= TRIP_ANGLE_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   pcr_sequencer #(
      .STATE_WIDTH (STATE_WIDTH)
   ) u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .status   (status),
      .req      (req_word),
      .cfg      (cfg_ff),
      .rsp      (seq_rsp),
      .mul_go   (mul_go),
      .mul_x    (mul_x),
      .mul_c    (mul_c),
      .mul_done (mul_done),
      .mul_y    (mul_y)
   );

   pcr_mul_unit #(
      .STATE_WIDTH (STATE_WIDTH)
   ) u_mul_unit (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .mul_x (mul_x),
      .mul_c (mul_c),
      .done  (mul_done),
      .mul_y (mul_y)
   );

endmodule

// ----- hw/rtl/pcr_checker.sv -----
// ----------------------------------------------------------------------------
// pcr_checker: port-level assertions for the pendulum cascade regulator
// Watches the handshakes and result words of the top level; bound below.
// ----------------------------------------------------------------------------
module pcr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input pcr_pkg::rsp_word_type           rsp_word
);
   import pcr_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // one word in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted word");

   // stopped words carry no drive
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.stopped |-> rsp_word.motor_drive == '0)
      else $error("drive nonzero while stopped");

   // a new result only appears after a word was taken in
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a word in work");

endmodule

bind pendulum_cascade_regulator pcr_checker u_pcr_checker (.*);

// ----- bench/pendulum_cascade_regulator_test.sv -----
// ----------------------------------------------------------------------------
// pendulum_cascade_regulator_test: self-checking bench for the regulator
// A driver feeds sample words from a backlog queue and forecasts each drive
// word with a bit-true Q.16 copy of the cascade loop. A monitor checks every
// drive word against the oldest forecast. The run steps through several
// deadzone, clamp and trip settings, with random idling on both channels, one
// long receiver stall, and a final emergency stop phase.
// ----------------------------------------------------------------------------
module pendulum_cascade_regulator_test;
   import pcr_pkg::*;

   localparam int STATE_BITS = STATE_W_DEFAULT;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int STALL_AT_WORD = 450;
   localparam int STALL_CYCLES  = 300;

   typedef struct {
      longint pend_out;
      longint pend_err;
      longint speed_err;
      longint speed_out;
      longint drive_last;
      bit     stopped;
   } loop_state_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]       csr_wdata = '0;

   req_word_type   sample_backlog[$];
   rsp_word_type   drive_forecast[$];
   loop_state_type st = '{default: 0};
   cfg_type        cfg = '{DEADZONE_RESET, DRIVE_LIMIT_RESET, TRIP_ANGLE_RESET};
   bit             quiet = 1'b0;
   int             mismatches = 0;
   int             drive_words_seen = 0;
   int             stall_left = 0;

   pendulum_cascade_regulator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint sat_to(input longint x, input int w);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      return x > hi ? hi : (x < lo ? lo : x);
   endfunction

   function automatic longint clip32(input longint x);
      return sat_to(x, STATE_BITS);
   endfunction

   // x times unsigned Q.16 gain, rounded half up
   function automatic longint qmul(input longint x, input logic [CONST_W-1:0] c);
      longint ip, fr;
      ip = longint'(c[CONST_W-1:FRAC_W]);
      fr = longint'(c[FRAC_W-1:0]);
      return clip32(x * ip + ((x * fr + 32768) >>> FRAC_W));
   endfunction

   // Loop up to the speed controller output; sets the stop flag on a trip
   // and then leaves the loop state alone.
   function automatic longint speed_demand(input req_word_type w);
      longint t16, a16, p16, ta, tp, vf, e, yp, ew, y, trip;
      t16 = clip32(longint'($signed(w.tacho_sample)) * 16);
      a16 = clip32(longint'($signed(w.arm_sample)) * 16);
      p16 = clip32(longint'($signed(w.pend_sample)) * 16);
      ta = qmul(clip32(a16 - longint'(K_ARM_ZERO)), K_RAD_ARM);
      trip = longint'(cfg.trip_angle) * 16;
      if (ta > trip || ta < -trip) begin
         st.stopped = 1'b1;
         return 0;
      end
      tp = qmul(clip32(p16 - longint'(K_PIND_ZERO)), K_RAD_PIND);
      vf = clip32(clip32(tp + ta) + qmul(ta, K_TILT));
      e = clip32(-vf);
      yp = clip32(qmul(st.pend_out, K_POLE) - qmul(e, K_ZERO_NEW));
      yp = clip32(yp + qmul(st.pend_err, K_ZERO_OLD));
      st.pend_err = e;
      st.pend_out = yp;
      ew = clip32(qmul(clip32(yp - ta), K_ARM_GAIN) + qmul(t16, K_INV_TACHO));
      y = clip32(qmul(ew, K_SPD_NEW) - qmul(st.speed_err, K_SPD_OLD));
      y = clip32(y + qmul(st.speed_out, K_SPD_FB));
      y = clip32(y + qmul(st.drive_last, K_SPD_DRV));
      st.speed_err = ew;
      st.speed_out = y;
      return y;
   endfunction

   function automatic rsp_word_type predict_drive(input req_word_type w);
      rsp_word_type r;
      longint u, dz, lim;
      r.motor_drive = '0;
      r.stopped = 1'b1;
      if (st.stopped) return r;
      u = speed_demand(w);
      if (st.stopped) return r;
      dz = longint'(cfg.deadzone_offset) * 16;
      lim = longint'(cfg.drive_limit) * 16;
      if (u > 0) u = clip32(u + dz);
      else if (u < 0) u = clip32(u - dz);
      if (u > lim) u = lim;
      if (u < -lim) u = -lim;
      st.drive_last = u;
      u = sat_to((u + 8) >>> 4, SAMPLE_W);
      r.motor_drive = u[SAMPLE_W-1:0];
      r.stopped = 1'b0;
      return r;
   endfunction

   // mostly near upright, the rest anywhere; tame keeps |arm angle| < 1.5 rad
   function automatic req_word_type random_sample(input bit tame);
      req_word_type w;
      w.tacho_sample = 16'($urandom);
      w.arm_sample = 16'($urandom);
      w.pend_sample = 16'($urandom);
      if ($urandom_range(99) < 70) begin
         w.tacho_sample = 16'(int'($urandom_range(600)) - 300);
         w.arm_sample = 16'(int'($urandom_range(4000)) + 4056);
         w.pend_sample = 16'(int'($urandom_range(1200)) + 2076);
      end
      if (tame) w.arm_sample = 16'(int'($urandom_range(15000)) - 1500);
      return w;
   endfunction

   task automatic offer_sample(input int t, input int a, input int p);
      req_word_type w;
      w.tacho_sample = 16'(t);
      w.arm_sample = 16'(a);
      w.pend_sample = 16'(p);
      sample_backlog.push_back(w);
   endtask

   task automatic offer_random(input int n, input bit tame);
      for (int i = 0; i < n; i++) sample_backlog.push_back(random_sample(tame));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEADZONE:    cfg.deadzone_offset = val;
         CSR_DRIVE_LIMIT: cfg.drive_limit = val;
         CSR_TRIP_ANGLE:  cfg.trip_angle = val;
         default: ;
      endcase
   endtask

   // sender holds off until every forecast drive word has come back
   task automatic drain();
      while (sample_backlog.size() != 0 || req_valid || drive_forecast.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // driver: one sample word per handshake, forecast taken at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) drive_forecast.push_back(predict_drive(req_word));
         if (!req_valid || req_ready) begin
            if (sample_backlog.size() != 0 && (quiet || $urandom_range(99) >= 22)) begin
               req_word <= sample_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each drive word with the oldest forecast
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            drive_words_seen++;
            if (drive_words_seen == STALL_AT_WORD) stall_left = STALL_CYCLES;
            if (drive_forecast.size() == 0) begin
               $display("%0t: drive word with none forecast: expected none, actual %h",
                        $time, rsp_word);
               mismatches++;
            end else begin
               want = drive_forecast.pop_front();
               if (rsp_word.motor_drive !== want.motor_drive) begin
                  $display("%0t: motor_drive expected %0d actual %0d", $time,
                           $signed(want.motor_drive), $signed(rsp_word.motor_drive));
                  mismatches++;
               end
               if (rsp_word.stopped !== want.stopped) begin
                  $display("%0t: stopped expected %0b actual %0b", $time,
                           want.stopped, rsp_word.stopped);
                  mismatches++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || $urandom_range(99) >= 22;
         end
      end
   end

   initial begin
      int a, p;
      longint d;
      bit found;
      loop_state_type saved;
      req_word_type probe;
      logic [CFG_W-1:0] dz_pick;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // From reset state with no tacho, speed demand is 4800*(yp - ta); a tacho
      // of 3k adds exactly 9600k, so an even small offset can be cancelled.
      found = 1'b0;
      saved = st;
      probe = '0;
      for (a = 6000; a <= 6110 && !found; a++) begin
         for (p = 2600; p <= 2750 && !found; p++) begin
            probe.tacho_sample = '0;
            probe.arm_sample = 16'(a);
            probe.pend_sample = 16'(p);
            st = saved;
            d = speed_demand(probe) / 4800;
            if (!st.stopped && d % 2 == 0 && d > -2000 && d < 2000) begin
               probe.tacho_sample = 16'((-3 * d) / 2);
               st = saved;
               if (speed_demand(probe) == 0 && !st.stopped) found = 1'b1;
            end
         end
      end
      st = saved;

      write_reg(CSR_TRIP_ANGLE, 15'd32767);
      // zero drive first, while the loop state is still clear
      sample_backlog.push_back(probe);
      offer_sample(32767, 32767, 32767);
      offer_sample(-32768, -32768, -32768);
      offer_sample(32767, -32768, 32767);
      offer_sample(-32768, 32767, -32768);
      offer_sample(0, 0, 0);
      offer_sample(1, -1, 1);
      offer_sample(-1, 1, -1);
      offer_sample(0, 6056, 2676);
      offer_sample(16384, -16384, 0);
      offer_sample(-21846, 21845, -21846);
      drain();

      write_reg(CSR_DEADZONE, 15'd0);
      write_reg(CSR_DRIVE_LIMIT, 15'd32767);
      quiet = 1'b1;
      offer_random(250, 1'b0);
      drain();
      quiet = 1'b0;

      // clamp below deadzone: clamp wins
      write_reg(CSR_DEADZONE, 15'd20480);
      write_reg(CSR_DRIVE_LIMIT, 15'd0);
      offer_sample(32767, 6056, 2676);
      offer_sample(-32768, 6056, 2676);
      offer_sample(0, 32767, -32768);
      offer_sample(0, -32768, 32767);
      offer_random(150, 1'b0);
      drain();

      dz_pick = 15'($urandom_range(20480, 1));
      write_reg(CSR_DEADZONE, dz_pick);
      write_reg(CSR_DRIVE_LIMIT, 15'($urandom_range(int'(dz_pick) - 1)));
      offer_random(150, 1'b0);
      drain();

      // unused index leaves every register as it was
      write_reg(CSR_UNUSED, 15'($urandom));
      offer_random(100, 1'b0);
      drain();

      write_reg(CSR_DEADZONE, 15'd32767);
      write_reg(CSR_DRIVE_LIMIT, 15'($urandom_range(32767)));
      offer_random(100, 1'b0);
      drain();

      write_reg(CSR_DEADZONE, DEADZONE_RESET);
      write_reg(CSR_DRIVE_LIMIT, DRIVE_LIMIT_RESET);
      write_reg(CSR_TRIP_ANGLE, TRIP_ANGLE_RESET);
      offer_random(100, 1'b1);
      drain();

      // zero trip angle: the first word trips, the rest see the latched stop
      write_reg(CSR_TRIP_ANGLE, 15'd0);
      offer_random(60, 1'b0);
      drain();

      repeat (60) @(posedge clock);
      if (mismatches == 0 && drive_forecast.size() == 0) begin
         $display("pendulum_cascade_regulator test passed");
      end else begin
         $display("pendulum_cascade_regulator test failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("pendulum_cascade_regulator test failed");
      $finish;
   end

endmodule
